// File: sv/lebr_pkg.sv
// Shared constants and controller/datapath handoff types for the
// longest equal bit run tracker. No dependencies.
package lebr_pkg;

    // Fixed field widths
    localparam int POS_W = 10;
    localparam int LEN_W = 11;

    // Largest reportable run
    localparam logic [LEN_W-1:0] RUN_MAX = '1;

    // Operation codes of an input item
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_FLIP = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_wr;    // write one clearing entry, advance sweep
        logic load;      // capture input item, read its leaf
        logic leaf_wr;   // write updated leaf, read its sibling
        logic climb;     // join with sibling, write parent, read next sibling
        logic q_init;    // start prefix walk from the root
        logic q_step;    // descend one level of the prefix walk
        logic q_leaf;    // read the last leaf of the prefix
        logic out_load;  // capture the result item
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;  // last clearing entry is being written
        logic ignored;   // captured position is out of range
        logic at_root;   // the next parent written is the root
        logic walk_last; // this walk step reaches the leaf level
    } t_sts;

endpackage

// File: sv/lebr_ifs.sv
// Channel interfaces (item in, result out, length write) of the tracker.
// Depends on lebr_pkg for field widths.
interface lebr_item_if import lebr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [POS_W-1:0] position;
    logic             bit_value;

    modport source (output valid, func, position, bit_value, input ready);
    modport sink   (input valid, func, position, bit_value, output ready);
endinterface

interface lebr_result_if import lebr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] longest_run;
    logic             position_ignored;

    modport source (output valid, longest_run, position_ignored, input ready);
    modport sink   (input valid, longest_run, position_ignored, output ready);
endinterface

interface lebr_cfg_if import lebr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] vector_length;

    modport source (output valid, vector_length, input ready);
    modport sink   (input valid, vector_length, output ready);
endinterface

// File: sv/longest_equal_bit_run_tracker.sv
// Top level of the longest equal bit run tracker: joins the controller
// and the datapath. Depends on lebr_pkg, lebr_ifs, lebr_ctrl, lebr_dp.
//
//   channel   dir  handshake      payload
//   i_item    in   valid/ready    func, position, bit_value
//   o_result  out  valid/ready    longest_run, position_ignored
//   i_cfg     in   valid/ready=1  vector_length
//
// An item passes a leaf update, a rejoin of the path to the root and a
// walk of the prefix of positions in use, both one tree level at a time,
// all through the single read port of the summary RAM. An out of range
// item skips the leaf update and the rejoin. After reset a clearing
// pass, with L = log2 of MAX_BITS rounded up, writes all 2**(L+1)-1
// tree nodes, one per cycle, before the first item is accepted. While a
// result waits in the output register one more item is accepted and
// processed; its result then holds the controller, and the input stalls.
module longest_equal_bit_run_tracker import lebr_pkg::*; #(
    parameter int MAX_BITS = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lebr_item_if.sink      i_item,
    lebr_result_if.source  o_result,
    lebr_cfg_if.sink       i_cfg
);

    t_cmd cmd;
    t_sts sts;

    // Length register always takes writes
    assign i_cfg.ready = 1'b1;

    lebr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lebr_dp #(
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_len          (i_cfg.vector_length),
        .i_func             (i_item.func),
        .i_position         (i_item.position),
        .i_bit_value        (i_item.bit_value),
        .o_longest_run      (o_result.longest_run),
        .o_position_ignored (o_result.position_ignored)
    );

endmodule

// File: sv/lebr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lebr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/lebr_ctrl.sv
// Sequencing controller of the tracker: clearing sweep, leaf update,
// climb to the root, prefix walk and result handoff. Depends on lebr_pkg.
module lebr_ctrl import lebr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF,
        S_CLIMB,
        S_QINIT,
        S_QWALK,
        S_QLEAF,
        S_QDRAIN,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;

    assign out_free = !r_out_vld || i_out_ready;

    // Decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LEAF;
                end
            end
            S_LEAF: begin
                if (i_sts.ignored) begin
                    n_state = S_QINIT;
                end else begin
                    o_cmd.leaf_wr = 1'b1;
                    n_state       = S_CLIMB;
                end
            end
            S_CLIMB: begin
                o_cmd.climb = 1'b1;
                if (i_sts.at_root) begin
                    n_state = S_QINIT;
                end
            end
            S_QINIT: begin
                o_cmd.q_init = 1'b1;
                n_state      = S_QWALK;
            end
            S_QWALK: begin
                o_cmd.q_step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_QLEAF;
                end
            end
            S_QLEAF: begin
                o_cmd.q_leaf = 1'b1;
                n_state      = S_QDRAIN;
            end
            S_QDRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on capture, drop when taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// File: sv/lebr_dp.sv
// Datapath of the tracker: length register, run summary tree in RAM
// (leaves are the bits), join logic and result register.
// Depends on lebr_pkg and lebr_ram.
module lebr_dp import lebr_pkg::*; #(
    parameter int MAX_BITS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_len,
    input  logic             i_func,
    input  logic [POS_W-1:0] i_position,
    input  logic             i_bit_value,
    output logic [LEN_W-1:0] o_longest_run,
    output logic             o_position_ignored
);

    // Tree geometry: leaves padded to a power of two
    localparam int AW    = $clog2(MAX_BITS);
    localparam int NW    = AW + 1;
    localparam int CW    = AW + 1;
    localparam int EW    = (CW > LEN_W) ? CW : LEN_W;
    localparam int DEPTH = 2 << AW;

    typedef struct packed {
        logic          first;
        logic          last;
        logic [CW-1:0] pre;
        logic [CW-1:0] suf;
        logic [CW-1:0] best;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    // Join two adjacent segments, a on the left
    function automatic t_node f_join(t_node a, logic [CW-1:0] a_len,
                                     t_node b, logic [CW-1:0] b_len);
        t_node         j;
        logic          link;
        logic [CW-1:0] mid;
        link    = (a.last == b.first);
        j.first = a.first;
        j.last  = b.last;
        j.pre   = (link && a.pre == a_len) ? CW'(a_len + b.pre) : a.pre;
        j.suf   = (link && b.suf == b_len) ? CW'(b_len + a.suf) : b.suf;
        mid     = link ? CW'(a.suf + b.pre) : '0;
        j.best  = a.best;
        if (b.best > j.best) begin
            j.best = b.best;
        end
        if (mid > j.best) begin
            j.best = mid;
        end
        return j;
    endfunction

    function automatic t_node f_leaf(logic b);
        t_node l;
        l.first = b;
        l.last  = b;
        l.pre   = CW'(1);
        l.suf   = CW'(1);
        l.best  = CW'(1);
        return l;
    endfunction

    // Registers
    logic [EW-1:0]    r_vl;
    logic [NW-1:0]    r_cidx;
    logic [CW-1:0]    r_clen;
    logic             r_func;
    logic             r_bit;
    logic             r_ign;
    logic [NW-1:0]    r_idx;
    t_node            r_cur;
    logic [CW-1:0]    r_len;
    logic [NW-1:0]    r_node;
    logic [AW-1:0]    r_m;
    logic [CW-1:0]    r_qlen;
    t_node            r_acc;
    logic [CW-1:0]    r_acc_len;
    logic             r_acc_vld;
    logic             r_pend;
    logic [CW-1:0]    r_pend_len;
    logic [LEN_W-1:0] r_run;
    logic             r_oign;

    // Memory port signals
    logic              we;
    logic [NW-1:0]     waddr;
    t_node             wdata;
    logic [NW-1:0]     raddr;
    logic [NODE_W-1:0] rdata_raw;
    t_node             rdata;

    logic [EW-1:0] eff_len;
    logic [EW-1:0] pos_ext;
    logic          ign_now;
    logic [AW-1:0] last_pos;
    logic [NW-1:0] parent;
    t_node         new_leaf;
    t_node         joined;
    t_node         acc_next;
    logic [EW-1:0] best_ext;

    lebr_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    assign rdata = t_node'(rdata_raw);

    // Effective length: zero acts as one, clamp to MAX_BITS
    always_comb begin
        if (r_vl == '0) begin
            eff_len = EW'(1);
        end else if (r_vl > EW'(MAX_BITS)) begin
            eff_len = EW'(MAX_BITS);
        end else begin
            eff_len = r_vl;
        end
    end

    assign pos_ext  = EW'(i_position);
    assign ign_now  = (pos_ext >= eff_len);
    assign last_pos = AW'(eff_len - EW'(1));
    assign parent   = r_idx >> 1;
    assign new_leaf = f_leaf((r_func == FUNC_FLIP) ? ~rdata.first : r_bit);
    assign joined   = r_idx[0] ? f_join(rdata, r_len, r_cur, r_len)
                               : f_join(r_cur, r_len, rdata, r_len);
    assign acc_next = r_acc_vld ? f_join(r_acc, r_acc_len, rdata, r_pend_len) : rdata;

    // Select write port
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = joined;
        if (i_cmd.clr_wr) begin
            we         = 1'b1;
            waddr      = r_cidx;
            wdata.first = 1'b0;
            wdata.last  = 1'b0;
            wdata.pre   = r_clen;
            wdata.suf   = r_clen;
            wdata.best  = r_clen;
        end else if (i_cmd.leaf_wr) begin
            we    = 1'b1;
            waddr = r_idx;
            wdata = new_leaf;
        end else if (i_cmd.climb) begin
            we    = 1'b1;
            waddr = parent;
            wdata = joined;
        end
    end

    // Select read address
    always_comb begin
        raddr = '0;
        if (i_cmd.load) begin
            raddr = {1'b1, pos_ext[AW-1:0]};
        end else if (i_cmd.leaf_wr) begin
            raddr = r_idx ^ NW'(1);
        end else if (i_cmd.climb) begin
            raddr = parent ^ NW'(1);
        end else if (i_cmd.q_step) begin
            raddr = {r_node[NW-2:0], 1'b0};
        end else if (i_cmd.q_leaf) begin
            raddr = r_node;
        end
    end

    // Control registers: length, clearing sweep, accumulator flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl      <= EW'(MAX_BITS);
            r_cidx    <= NW'(1);
            r_clen    <= CW'(1) << AW;
            r_acc_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vl <= EW'(i_cfg_len);
            end
            if (i_cmd.clr_wr) begin
                r_cidx <= r_cidx + NW'(1);
                if ((r_cidx & (r_cidx + NW'(1))) == '0) begin
                    r_clen <= r_clen >> 1;
                end
            end
            // Accumulate pending prefix node
            if (i_cmd.q_init) begin
                r_acc_vld <= 1'b0;
            end else if (r_pend) begin
                r_acc_vld <= 1'b1;
            end
            r_pend <= (i_cmd.q_step && r_m[AW-1]) || i_cmd.q_leaf;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // Capture item and leaf index
        if (i_cmd.load) begin
            r_func <= i_func;
            r_bit  <= i_bit_value;
            r_ign  <= ign_now;
            r_idx  <= {1'b1, pos_ext[AW-1:0]};
        end
        // Update leaf, then climb one level a cycle
        if (i_cmd.leaf_wr) begin
            r_cur <= new_leaf;
            r_len <= CW'(1);
        end else if (i_cmd.climb) begin
            r_cur <= joined;
            r_len <= CW'(r_len + r_len);
            r_idx <= parent;
        end
        // Walk from the root toward the last position in use
        if (i_cmd.q_init) begin
            r_node    <= NW'(1);
            r_m       <= last_pos;
            r_qlen    <= CW'(1) << (AW - 1);
            r_acc_len <= '0;
        end else if (i_cmd.q_step) begin
            r_node <= {r_node[NW-2:0], r_m[AW-1]};
            r_m    <= r_m << 1;
            r_qlen <= r_qlen >> 1;
        end
        if (i_cmd.q_step) begin
            r_pend_len <= r_qlen;
        end else if (i_cmd.q_leaf) begin
            r_pend_len <= CW'(1);
        end
        if (r_pend) begin
            r_acc     <= acc_next;
            r_acc_len <= CW'(r_acc_len + r_pend_len);
        end
        // Capture result, saturate the run
        if (i_cmd.out_load) begin
            r_run  <= (best_ext > EW'(RUN_MAX)) ? RUN_MAX : best_ext[LEN_W-1:0];
            r_oign <= r_ign;
        end
    end

    assign best_ext = EW'(r_acc.best);

    assign o_sts.clr_done  = &r_cidx;
    assign o_sts.ignored   = r_ign;
    assign o_sts.at_root   = (parent == NW'(1));
    assign o_sts.walk_last = (r_qlen == CW'(1));

    assign o_longest_run      = r_run;
    assign o_position_ignored = r_oign;

endmodule

// File: tb/lebr_run_checker.sv
// Scoreboard for the longest equal bit run tracker: watches the item, result
// and length channels, predicts each result and compares it field by field.
// Depends on lebr_pkg and lebr_ifs.
module lebr_run_checker import lebr_pkg::*; #(
    parameter int MAX_BITS = 1024
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lebr_item_if   i_item,
    lebr_result_if i_result,
    lebr_cfg_if    i_cfg,
    output int     o_errors,
    output int     o_pending
);

    typedef struct packed {
        logic [LEN_W-1:0] longest_run;
        logic             position_ignored;
    } t_run_result;

    // Shadow copy of the bit store and the length register
    logic             bit_vec [MAX_BITS];
    logic [LEN_W-1:0] length_reg;

    t_run_result      expected_runs [$];
    t_run_result      want;
    int               error_count;

    assign o_errors = error_count;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
        error_count++;
    endtask

    // Apply one item to the shadow store, then scan the positions in use
    function automatic t_run_result apply_and_measure(
        input logic f, input logic [POS_W-1:0] p, input logic b
    );
        t_run_result r;
        int          n;
        int          best;
        int          run;
        n = (length_reg == '0) ? 1 :
            (int'(length_reg) > MAX_BITS) ? MAX_BITS : int'(length_reg);
        r.position_ignored = (int'(p) >= n);
        if (!r.position_ignored) begin
            if (f == FUNC_LOAD) begin
                bit_vec[p] = b;
            end else begin
                bit_vec[p] = ~bit_vec[p];
            end
        end
        best = 0;
        run  = 0;
        for (int i = 0; i < n; i++) begin
            run = (i > 0 && bit_vec[i] == bit_vec[i-1]) ? run + 1 : 1;
            if (run > best) best = run;
        end
        if (best > int'(RUN_MAX)) best = int'(RUN_MAX);
        r.longest_run = LEN_W'(best);
        return r;
    endfunction

    // Track length writes, check results, queue predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BITS; i++) bit_vec[i] = 1'b0;
            length_reg = LEN_W'(MAX_BITS);
            expected_runs.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) length_reg = i_cfg.vector_length;
            if (i_result.valid && i_result.ready) begin
                if (expected_runs.size() == 0) begin
                    report_mismatch("unexpected result, longest_run",
                                    int'(i_result.longest_run), -1);
                end else begin
                    want = expected_runs.pop_front();
                    if (i_result.longest_run !== want.longest_run)
                        report_mismatch("longest_run", int'(i_result.longest_run),
                                        int'(want.longest_run));
                    if (i_result.position_ignored !== want.position_ignored)
                        report_mismatch("position_ignored",
                                        int'(i_result.position_ignored),
                                        int'(want.position_ignored));
                end
            end
            if (i_item.valid && i_item.ready)
                expected_runs.push_back(apply_and_measure(i_item.func, i_item.position,
                                                          i_item.bit_value));
        end
        o_pending <= expected_runs.size();
    end

endmodule

// File: tb/tb.sv
// Top of the tracker testbench: clock, reset, item and length stimulus,
// result back-pressure and the verdict. Depends on lebr_pkg, lebr_ifs,
// lebr_run_checker and the tracker RTL.
module tb import lebr_pkg::*;;

    localparam int CLK_PERIOD     = 20;
    localparam int MAX_BITS       = 1024;
    localparam int RANDOM_ITEMS   = 700;
    localparam int CALM_ITEMS     = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES = 300000;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   expected_left;
    int   sent_count;
    int   cur_len;
    bit   tx_idle;
    bit   rx_idle;
    bit   hold_request;

    lebr_item_if   item_ch ();
    lebr_result_if result_ch ();
    lebr_cfg_if    cfg_ch ();

    longest_equal_bit_run_tracker #(.MAX_BITS(MAX_BITS)) i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    lebr_run_checker #(.MAX_BITS(MAX_BITS)) i_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_item    (item_ch),
        .i_result  (result_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (mismatch_count),
        .o_pending (expected_left)
    );

    // Free-running clock
    always begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Clamp a length value the way the block does
    function automatic int usable_bits(input logic [LEN_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_BITS) return MAX_BITS;
        return int'(v);
    endfunction

    // Offer one item, with an optional gap first; return once it is taken
    task automatic send_item(input logic f, input int p, input logic b);
        int gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
        @(negedge clk);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.func      <= f;
        item_ch.position  <= POS_W'(p);
        item_ch.bit_value <= b;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    // Drop the item channel and wait until every result is back
    task automatic drain_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0) @(posedge clk);
    endtask

    // Write the length register while the block is idle
    task automatic write_length(input logic [LEN_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.vector_length <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_len = usable_bits(v);
    endtask

    // Reload the low bits with long runs of equal values
    task automatic reload_bits(input int count);
        logic v;
        v = 1'($urandom_range(0, 1));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0) v = ~v;
            send_item(FUNC_LOAD, i, v);
        end
    endtask

    // Pick the next length: mostly short, sometimes the extremes
    function automatic logic [LEN_W-1:0] pick_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 5))
                0: return LEN_W'(0);
                1: return LEN_W'(1);
                2: return LEN_W'(2);
                3: return LEN_W'(MAX_BITS);
                4: return LEN_W'(MAX_BITS + 1);
                default: return RUN_MAX;
            endcase
        end
        if (sel == 1) return LEN_W'($urandom_range(97, 2047));
        return LEN_W'($urandom_range(1, 64));
    endfunction

    // Result side: random back-pressure bursts and one long hold-off
    initial begin
        result_ch.ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                result_ch.ready <= 1'b1;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int          total;
        int          ops;
        int          p;
        logic        f;
        bit          first_phase;
        item_ch.valid        = 1'b0;
        item_ch.func         = FUNC_LOAD;
        item_ch.position     = '0;
        item_ch.bit_value    = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.vector_length = '0;
        rst_n                = 1'b0;
        sent_count           = 0;
        cur_len              = MAX_BITS;
        tx_idle              = 1'b0;
        rx_idle              = 1'b0;
        hold_request         = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Full length after reset: ends of the vector, all-equal, alternating bits
        send_item(FUNC_LOAD, 0, 1'b1);
        send_item(FUNC_LOAD, MAX_BITS - 1, 1'b1);
        send_item(FUNC_FLIP, 0, 1'b1);
        send_item(FUNC_FLIP, MAX_BITS - 1, 1'b0);
        send_item(FUNC_LOAD, 'h2AA, 1'b1);
        send_item(FUNC_LOAD, 'h155, 1'b1);
        send_item(FUNC_FLIP, 'h2AA, 1'b0);
        send_item(FUNC_FLIP, 'h155, 1'b1);
        send_item(FUNC_LOAD, 0, 1'b0);

        // Shortest length: everything past bit 0 is ignored
        write_length(LEN_W'(1));
        send_item(FUNC_LOAD, 0, 1'b1);
        send_item(FUNC_LOAD, 1, 1'b1);
        send_item(FUNC_FLIP, MAX_BITS - 1, 1'b0);
        send_item(FUNC_FLIP, 0, 1'b0);

        // Zero length acts as one
        write_length(LEN_W'(0));
        send_item(FUNC_FLIP, 0, 1'b0);
        send_item(FUNC_LOAD, 1, 1'b1);

        // Oversized length acts as the full vector
        write_length(RUN_MAX);
        send_item(FUNC_LOAD, MAX_BITS - 1, 1'b1);
        send_item(FUNC_FLIP, MAX_BITS - 1, 1'b1);

        // Two bits: alternating and equal
        write_length(LEN_W'(2));
        send_item(FUNC_LOAD, 0, 1'b0);
        send_item(FUNC_LOAD, 1, 1'b1);
        send_item(FUNC_FLIP, 1, 1'b0);
        send_item(FUNC_LOAD, 2, 1'b1);

        write_length(LEN_W'(MAX_BITS + 1));
        send_item(FUNC_LOAD, MAX_BITS - 1, 1'b0);

        // Random phases: new length, reload, then mixed loads and flips
        total       = sent_count + RANDOM_ITEMS;
        first_phase = 1'b1;
        while (sent_count < total) begin
            write_length(pick_length());
            if (sent_count >= total - CALM_ITEMS) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else begin
                tx_idle = 1'($urandom_range(0, 1));
                rx_idle = 1'($urandom_range(0, 1));
            end
            reload_bits((cur_len <= 96) ? cur_len : 64);
            ops = $urandom_range(15, 40);
            for (int k = 0; k < ops; k++) begin
                if (cur_len < MAX_BITS && $urandom_range(0, 99) < 12) begin
                    p = $urandom_range(cur_len, MAX_BITS - 1);
                end else begin
                    p = $urandom_range(0, cur_len - 1);
                end
                f = $urandom_range(0, 1) ? FUNC_FLIP : FUNC_LOAD;
                send_item(f, p, 1'($urandom_range(0, 1)));
                // Stall the results for a long stretch while items keep coming
                if (first_phase && k == 0) hold_request = 1'b1;
            end
            first_phase = 1'b0;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_left == 0) begin
            $display("[longest_equal_bit_run_tracker] OK");
        end else begin
            $display("[longest_equal_bit_run_tracker] ERROR");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[longest_equal_bit_run_tracker] ERROR");
        $finish;
    end

endmodule

// File: files.f
sv/lebr_pkg.sv
sv/lebr_ifs.sv
sv/lebr_ram.sv
sv/lebr_ctrl.sv
sv/lebr_dp.sv
sv/longest_equal_bit_run_tracker.sv
tb/lebr_run_checker.sv
tb/tb.sv
